@@ sv/owf_pkg.sv @@
// Shared constants, types and helpers of the overlapping window framer.
package owf_pkg;

	localparam int WINDOW_SIZE = 64;
	localparam int HOP_SIZE    = 32;
	localparam int CHANNELS    = 2;

	localparam int OUT_LANES = 2;
	localparam int SAMPLE_W  = 32;
	localparam int INDEX_W   = 64;
	localparam int RATE_W    = 32;
	localparam int CNT_W     = 8;
	localparam int LOCK_W    = 2;
	localparam int POS_W     = 6;

	localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W   = SLOT_W + 1;
	localparam int HOP_MOD = HOP_SIZE % WINDOW_SIZE;
	localparam int KEEP    = WINDOW_SIZE - HOP_SIZE;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_RESET = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_ACCEPT = 2'd0,
		STAT_SAMPLE = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [INDEX_W-1:0]    frame_index;
		logic [RATE_W-1:0]     stream_rate;
		logic [CNT_W-1:0]      channel_count;
		logic [SAMPLE_W-1:0]   sample_ch0;
		logic [SAMPLE_W-1:0]   sample_ch1;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic [INDEX_W-1:0]    window_start;
		logic [RATE_W-1:0]     locked_rate;
		logic [LOCK_W-1:0]     locked_channels;
		logic [POS_W-1:0]      position;
		logic [SAMPLE_W-1:0]   out_ch0;
		logic [SAMPLE_W-1:0]   out_ch1;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] window_start;
		logic [RATE_W-1:0]  locked_rate;
		logic [LOCK_W-1:0]  locked_channels;
	} meta_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
	} mem_acc_t;

	typedef struct packed {
		logic              en;
		logic              sample;
		status_t           status;
		logic [SLOT_W-1:0] position;
		logic              last;
	} load_t;

	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(WINDOW_SIZE)) ? (s - SUM_W'(WINDOW_SIZE)) : s;
		return r[SLOT_W-1:0];
	endfunction

endpackage

@@ sv/owf_in_if.sv @@
// Frame input channel: valid/ready handshake with one frame item.
interface owf_in_if;
	import owf_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/owf_out_if.sv @@
// Result output channel: valid/ready handshake with one result item.
interface owf_out_if;
	import owf_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/owf_lane.sv @@
// One channel lane: window sample memory with one write and one registered read port.
module owf_lane (
	input  logic                              clk,
	input  owf_pkg::mem_acc_t                 wr,
	input  logic [owf_pkg::SAMPLE_W-1:0]      wr_data,
	input  owf_pkg::mem_acc_t                 rd,
	output logic [owf_pkg::SAMPLE_W-1:0]      rd_data_s1
);
	import owf_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [WINDOW_SIZE];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.slot] <= wr_data;
		end
		if (rd.en) begin
			rd_data_s1 <= mem_q[rd.slot];
		end
	end
endmodule

@@ sv/owf_ctrl.sv @@
// Frame validation, stream locks, fill and read pointers, window readout sequencer.
module owf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  owf_pkg::in_item_t  in_data,
	output logic               in_ready,
	input  logic               out_free,
	output owf_pkg::mem_acc_t  wr,
	output owf_pkg::mem_acc_t  rd,
	output owf_pkg::load_t     ld,
	output owf_pkg::meta_t     meta
);
	import owf_pkg::*;

	fsm_t               state_q, state_nxt;
	logic               active_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SLOT_W-1:0]  base_q;
	logic [RATE_W-1:0]  rate_q;
	logic [LOCK_W-1:0]  chan_q;
	logic [INDEX_W-1:0] start_q;
	logic [INDEX_W-1:0] next_q;
	logic [FILL_W-1:0]  rd_cnt_q;
	logic               valid_s1;
	logic [SLOT_W-1:0]  pos_s1;
	logic               last_s1;

	logic              acc, is_reset, bad, mismatch, push_ok, full;
	logic              load_s1, issue, done;
	logic [FILL_W-1:0] fill_nxt;

	assign acc      = in_valid && in_ready;
	assign is_reset = (in_data.opcode == OP_RESET);
	assign bad      = (in_data.channel_count == '0) ||
	                  (in_data.channel_count > CNT_W'(CHANNELS)) ||
	                  (in_data.stream_rate == '0) || (&in_data.frame_index);
	assign mismatch = active_q && ((in_data.stream_rate != rate_q) ||
	                  (in_data.channel_count != CNT_W'(chan_q)) ||
	                  (in_data.frame_index != next_q));
	assign push_ok  = !is_reset && !bad && !mismatch;
	assign fill_nxt = fill_q + 1'b1;
	assign full     = (fill_nxt == FILL_W'(WINDOW_SIZE));
	assign load_s1  = valid_s1 && out_free;
	assign done     = load_s1 && last_s1;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && push_ok && full) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (done) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE) && out_free;
		issue    = (state_q == S_EMIT) && (rd_cnt_q != FILL_W'(WINDOW_SIZE)) &&
		           (!valid_s1 || load_s1);

		wr.en   = acc && push_ok;
		wr.slot = wrap_slot(SUM_W'(base_q) + SUM_W'(fill_q));
		rd.en   = issue;
		rd.slot = wrap_slot(SUM_W'(base_q) + SUM_W'(rd_cnt_q));

		if (load_s1) begin
			ld.en       = 1'b1;
			ld.sample   = 1'b1;
			ld.status   = STAT_SAMPLE;
			ld.position = pos_s1;
			ld.last     = last_s1;
		end else begin
			ld.en       = acc && !(push_ok && full);
			ld.sample   = 1'b0;
			ld.status   = (is_reset || push_ok) ? STAT_ACCEPT : STAT_REJECT;
			ld.position = '0;
			ld.last     = 1'b1;
		end

		if (acc && is_reset) begin
			meta = '0;
		end else if (acc && push_ok && !active_q) begin
			meta.window_start    = in_data.frame_index;
			meta.locked_rate     = in_data.stream_rate;
			meta.locked_channels = in_data.channel_count[LOCK_W-1:0];
		end else begin
			meta.window_start    = start_q;
			meta.locked_rate     = rate_q;
			meta.locked_channels = chan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= 1'b0;
			fill_q   <= '0;
			base_q   <= '0;
			rate_q   <= '0;
			chan_q   <= '0;
			start_q  <= '0;
			next_q   <= '0;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc) begin
				rd_cnt_q <= '0;
				if (is_reset) begin
					active_q <= 1'b0;
					fill_q   <= '0;
					base_q   <= '0;
					rate_q   <= '0;
					chan_q   <= '0;
					start_q  <= '0;
					next_q   <= '0;
				end else if (push_ok) begin
					if (!active_q) begin
						rate_q  <= in_data.stream_rate;
						chan_q  <= in_data.channel_count[LOCK_W-1:0];
						start_q <= in_data.frame_index;
					end
					active_q <= 1'b1;
					fill_q   <= fill_nxt;
					next_q   <= in_data.frame_index + 1'b1;
				end
			end
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (done) begin
				base_q  <= wrap_slot(SUM_W'(base_q) + SUM_W'(HOP_MOD));
				fill_q  <= FILL_W'(KEEP);
				start_q <= start_q + INDEX_W'(HOP_SIZE);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (load_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= rd_cnt_q[SLOT_W-1:0];
			last_s1 <= (rd_cnt_q == FILL_W'(WINDOW_SIZE - 1));
		end
	end
endmodule

@@ sv/owf_merge.sv @@
// Output register: combines lane read data with stream metadata into one result.
module owf_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  owf_pkg::load_t                             ld,
	input  owf_pkg::meta_t                             meta,
	input  logic [owf_pkg::OUT_LANES-1:0][owf_pkg::SAMPLE_W-1:0] rd_data,
	output logic                                       out_free,
	owf_out_if.source                                  result
);
	import owf_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld.en) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.en) begin
			data_q.status          <= ld.status;
			data_q.window_start    <= meta.window_start;
			data_q.locked_rate     <= meta.locked_rate;
			data_q.locked_channels <= meta.locked_channels;
			data_q.position        <= POS_W'(ld.position);
			data_q.out_ch0         <= ld.sample ? rd_data[0] : '0;
			data_q.out_ch1         <= (ld.sample && (meta.locked_channels > LOCK_W'(1))) ?
			                          rd_data[1] : '0;
			data_q.last            <= ld.last;
		end
	end

	assign out_free     = !valid_q || result.ready;
	assign result.valid = valid_q;
	assign result.data  = data_q;
endmodule

@@ sv/overlapping_window_framer.sv @@
// Overlapping window framer: top level with control, channel lanes and output merge.
//
// Each transfer on frame carries one audio frame or a reset command. A frame that does not
// complete a window, a rejected frame and a reset each give one result; such frames can
// stream at one per cycle while result is drained. The frame that completes a window gives
// WINDOW_SIZE results: each channel lane reads one slot per cycle, while result is ready,
// from its own window memory through a registered read port, and frame stays not ready
// until the final sample is in the output register. The window memories need no clearing
// after reset: a slot is always written before it is read.
module overlapping_window_framer (
	input  logic      clk,
	input  logic      arst_n,
	owf_in_if.sink    frame,
	owf_out_if.source result
);
	import owf_pkg::*;

	mem_acc_t wr, rd;
	load_t    ld;
	meta_t    meta;
	logic     out_free;
	logic     in_ready;

	logic [OUT_LANES-1:0][SAMPLE_W-1:0] samp;
	logic [OUT_LANES-1:0][SAMPLE_W-1:0] rd_data;

	assign samp[0]     = frame.data.sample_ch0;
	assign samp[1]     = frame.data.sample_ch1;
	assign frame.ready = in_ready;

	owf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_data  (frame.data),
		.in_ready (in_ready),
		.out_free (out_free),
		.wr       (wr),
		.rd       (rd),
		.ld       (ld),
		.meta     (meta)
	);

	for (genvar c = 0; c < OUT_LANES; c++) begin : g_lane
		if (c < CHANNELS) begin : g_used
			logic [SAMPLE_W-1:0] wr_data;

			assign wr_data = (CNT_W'(c) < frame.data.channel_count) ? samp[c] : '0;

			owf_lane u_lane (
				.clk        (clk),
				.wr         (wr),
				.wr_data    (wr_data),
				.rd         (rd),
				.rd_data_s1 (rd_data[c])
			);
		end else begin : g_unused
			assign rd_data[c] = '0;
		end
	end

	owf_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.meta     (meta),
		.rd_data  (rd_data),
		.out_free (out_free),
		.result   (result)
	);
endmodule

@@ sv/owf_checker.sv @@
// Port-level checks of the framer, attached to the top level by bind.
module owf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input owf_pkg::out_item_t  out_data
);
	import owf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STAT_SAMPLE) |->
		out_data.last && (out_data.position == '0) &&
		(out_data.out_ch0 == '0) && (out_data.out_ch1 == '0))
		else $error("non-sample result malformed");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_SAMPLE) && out_data.last |->
		(out_data.position == POS_W'(WINDOW_SIZE - 1)))
		else $error("window ended at wrong position");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_SAMPLE) && !out_data.last |-> !in_ready)
		else $error("frame taken during window readout");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (out_data.status == STAT_SAMPLE) && !out_data.last |=>
		out_valid && (out_data.status == STAT_SAMPLE) &&
		(out_data.position == POS_W'($past(out_data.position) + 1'b1)))
		else $error("window samples not contiguous");
endmodule

bind overlapping_window_framer owf_checker u_owf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (frame.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

@@ tb/overlapping_window_framer_tb.sv @@
// Testbench of the overlapping window framer: queued frames, in-bench window predictor, result check.
module overlapping_window_framer_tb;
	import owf_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 40;
	localparam int REPORT_MAX  = 10;

	typedef enum int {
		PACE_FREE,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	logic clk;
	logic arst_n;

	owf_in_if  frame_bus ();
	owf_out_if result_bus ();

	overlapping_window_framer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_bus),
		.result (result_bus)
	);

	// predicted framer state
	logic [SAMPLE_W-1:0] lane_mem [OUT_LANES][WINDOW_SIZE];
	int unsigned         rd_base;
	int unsigned         fill_cnt;
	bit                  streaming;
	logic [RATE_W-1:0]   rate_lk;
	logic [LOCK_W-1:0]   chan_lk;
	logic [INDEX_W-1:0]  win_start;
	logic [INDEX_W-1:0]  next_idx;

	in_item_t  pending_frames [$];
	out_item_t expected_results [$];

	// stream being generated
	logic [INDEX_W-1:0] gen_idx;
	logic [RATE_W-1:0]  gen_rate;
	logic [CNT_W-1:0]   gen_chans;

	int sent_count   = 0;
	int taken_count  = 0;
	int result_count = 0;
	int window_count = 0;
	int reject_count = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit hold_started = 1'b0;
	bit offering     = 1'b0;

	function automatic void clear_framer();
		foreach (lane_mem[c, s])
			lane_mem[c][s] = '0;
		rd_base   = 0;
		fill_cnt  = 0;
		streaming = 1'b0;
		rate_lk   = '0;
		chan_lk   = '0;
		win_start = '0;
		next_idx  = '0;
	endfunction

	function automatic void expect_result(status_t st, int pos, logic [SAMPLE_W-1:0] s0,
			logic [SAMPLE_W-1:0] s1, logic last);
		out_item_t r;
		r.status          = st;
		r.window_start    = win_start;
		r.locked_rate     = rate_lk;
		r.locked_channels = chan_lk;
		r.position        = POS_W'(pos);
		r.out_ch0         = s0;
		r.out_ch1         = s1;
		r.last            = last;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_frame(in_item_t it);
		int unsigned slot;
		int unsigned s;
		if (it.opcode == OP_RESET) begin
			clear_framer();
			expect_result(STAT_ACCEPT, 0, '0, '0, 1'b1);
			return;
		end
		if (it.channel_count == 0 || it.channel_count > CHANNELS || it.stream_rate == 0
				|| it.frame_index == '1
				|| (streaming && (it.stream_rate != rate_lk
				|| it.channel_count != CNT_W'(chan_lk) || it.frame_index != next_idx))) begin
			expect_result(STAT_REJECT, 0, '0, '0, 1'b1);
			return;
		end
		if (!streaming) begin
			rate_lk   = it.stream_rate;
			chan_lk   = LOCK_W'(it.channel_count);
			win_start = it.frame_index;
			streaming = 1'b1;
		end
		slot = (rd_base + fill_cnt) % WINDOW_SIZE;
		lane_mem[0][slot] = it.sample_ch0;
		lane_mem[1][slot] = (it.channel_count > 1) ? it.sample_ch1 : '0;
		fill_cnt++;
		next_idx = it.frame_index + 1;
		if (fill_cnt < WINDOW_SIZE) begin
			expect_result(STAT_ACCEPT, 0, '0, '0, 1'b1);
			return;
		end
		for (int k = 0; k < WINDOW_SIZE; k++) begin
			s = (rd_base + k) % WINDOW_SIZE;
			expect_result(STAT_SAMPLE, k, lane_mem[0][s], (chan_lk > 1) ? lane_mem[1][s] : '0,
				k == WINDOW_SIZE - 1);
		end
		rd_base   = (rd_base + HOP_SIZE) % WINDOW_SIZE;
		fill_cnt  = KEEP;
		win_start = win_start + INDEX_W'(HOP_SIZE);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_frame(logic [INDEX_W-1:0] idx, logic [RATE_W-1:0] rate,
			logic [CNT_W-1:0] chans, logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1);
		in_item_t it;
		it.opcode        = OP_PUSH;
		it.frame_index   = idx;
		it.stream_rate   = rate;
		it.channel_count = chans;
		it.sample_ch0    = s0;
		it.sample_ch1    = s1;
		pending_frames.push_back(it);
	endfunction

	// payload of a reset command is random and must be ignored
	function automatic void queue_reset();
		in_item_t it;
		it.opcode        = OP_RESET;
		it.frame_index   = {$urandom, $urandom};
		it.stream_rate   = $urandom;
		it.channel_count = CNT_W'($urandom);
		it.sample_ch0    = $urandom;
		it.sample_ch1    = $urandom;
		pending_frames.push_back(it);
	endfunction

	// a frame that must be rejected while the generated stream is active
	function automatic void queue_noise();
		logic [INDEX_W-1:0] idx;
		logic [RATE_W-1:0]  rate;
		logic [CNT_W-1:0]   chans;
		idx   = gen_idx;
		rate  = gen_rate;
		chans = gen_chans;
		case ($urandom_range(6))
			0: rate = '0;
			1: chans = '0;
			2: chans = CNT_W'($urandom_range(255, CHANNELS + 1));
			3: idx = '1;
			4: rate = gen_rate ^ (RATE_W'(1) << $urandom_range(RATE_W - 1));
			5: chans = CNT_W'(CHANNELS + 1) - gen_chans;
			default: begin
				if ($urandom_range(1))
					idx = gen_idx - 1;
				else
					idx = gen_idx + INDEX_W'($urandom_range(1000, 1));
			end
		endcase
		queue_frame(idx, rate, chans, pick_sample(), pick_sample());
	endfunction

	function automatic void run_stream(int n_valid, logic [CNT_W-1:0] chans);
		queue_reset();
		gen_idx = {$urandom, $urandom};
		if (gen_idx > 64'hFFFF_FFFF_FFFF_F000)
			gen_idx = gen_idx - 64'h1000;
		gen_rate = $urandom;
		if (gen_rate == 0)
			gen_rate = 1;
		gen_chans = chans;
		for (int i = 0; i < n_valid; i++) begin
			if (i > 0 && $urandom_range(99) < 5)
				queue_noise();
			queue_frame(gen_idx, gen_rate, gen_chans, pick_sample(), pick_sample());
			gen_idx = gen_idx + 1;
		end
	endfunction

	function automatic pace_t pace_of(int n);
		if (n < 30)
			return PACE_FREE;
		if (n < 60)
			return PACE_SRC_IDLE;
		if (n < 90)
			return PACE_SNK_STALL;
		return PACE_BOTH;
	endfunction

	function automatic int stall_pct(pace_t p, bit rx);
		case (p)
			PACE_SRC_IDLE:  return rx ? 0 : 70;
			PACE_SNK_STALL: return rx ? 70 : 0;
			PACE_BOTH:      return 12;
			default:        return 0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			frame_bus.valid <= 1'b0;
			frame_bus.data  <= '0;
		end else begin
			if (offering && sent_count != taken_count) begin
				void'(pending_frames.pop_front());
				taken_count++;
				offering = 1'b0;
			end
			if (!offering && pending_frames.size() != 0
					&& $urandom_range(99) >= stall_pct(pace_of(sent_count), 1'b0))
				offering = 1'b1;
			frame_bus.valid <= offering;
			if (offering)
				frame_bus.data <= pending_frames[0];
		end
	end

	always @(negedge clk) begin
		result_bus.ready <= (hold_left == 0)
			&& ($urandom_range(99) >= stall_pct(pace_of(sent_count), 1'b1));
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin
		if (!hold_started && sent_count >= HOLD_AT) begin
			hold_started <= 1'b1;
			hold_left    <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (frame_bus.valid && frame_bus.ready) begin
			predict_frame(frame_bus.data);
			sent_count <= sent_count + 1;
		end
		if (result_bus.valid && result_bus.ready) begin
			got = result_bus.data;
			result_count++;
			if (got.status == STAT_REJECT)
				reject_count++;
			if (got.status == STAT_SAMPLE && got.last)
				window_count++;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("result %0d arrived with nothing expected, status %0d",
						result_count, got.status);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("result %0d want st=%0d ws=%h rate=%h ch=%0d pos=%0d s0=%h s1=%h l=%b",
							result_count, want.status, want.window_start, want.locked_rate,
							want.locked_channels, want.position, want.out_ch0, want.out_ch1,
							want.last);
						$display("result %0d got  st=%0d ws=%h rate=%h ch=%0d pos=%0d s0=%h s1=%h l=%b",
							result_count, got.status, got.window_start, got.locked_rate,
							got.locked_channels, got.position, got.out_ch0, got.out_ch1,
							got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		clear_framer();

		// reset command on an empty framer, then bad frames while inactive
		queue_reset();
		queue_frame(64'd5, '0, 8'd1, '1, '1);
		queue_frame(64'd5, 32'd48000, '0, '1, '1);
		queue_frame(64'd5, 32'd48000, 8'd3, '1, '1);
		queue_frame(64'd5, 32'd48000, '1, '1, '1);
		queue_frame('1, 32'd48000, 8'd2, '1, '1);
		// stream start at index zero with the largest rate, then mismatches
		queue_frame(64'd0, '1, 8'd2, '1, '0);
		queue_frame(64'd1, '1, 8'd2, '0, '1);
		queue_frame(64'd2, 32'd1, 8'd2, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_frame(64'd2, '1, 8'd1, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_frame(64'd3, '1, 8'd2, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_frame(64'd1, '1, 8'd2, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_frame('1, '1, 8'd2, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_frame(64'd2, '1, 8'd2, 32'h5555_AAAA, 32'hAAAA_5555);
		queue_reset();
		// single channel stream that runs into the top of the index range
		queue_frame(64'hFFFF_FFFF_FFFF_FFFD, 32'd1, 8'd1, 32'h8000_0001, '1);
		queue_frame(64'hFFFF_FFFF_FFFF_FFFE, 32'd1, 8'd1, 32'h7FFF_FFFE, '1);
		queue_frame(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 8'd1, 32'h0000_0001, '1);
		queue_reset();
		queue_reset();

		// two overlapping windows on a stereo stream
		run_stream(96, 8'd2);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_frames.size() != 0)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (WINDOW_SIZE + 8) @(negedge clk);

		$display("%0d frame transfers, %0d result transfers, %0d windows read out, %0d rejects",
			sent_count, result_count, window_count, reject_count);
		$display("stereo stream with hop, short mono stream at index limit, both-side stalls, %0d mismatches",
			fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/owf_pkg.sv
sv/owf_in_if.sv
sv/owf_out_if.sv
sv/owf_lane.sv
sv/owf_ctrl.sv
sv/owf_merge.sv
sv/overlapping_window_framer.sv
sv/owf_checker.sv
tb/overlapping_window_framer_tb.sv
